FILE: rtl/core/kci_pkg.sv
// shared types, constants and datapath operation codes of the keyframe curve interpolator
package kci_pkg;

    localparam int KCI_MAX_KEYS = 64;
    localparam int ONE_Q16      = 65536;
    localparam int DIV_STEPS    = 48;

    typedef struct packed {
        logic [31:0]        ktime;
        logic signed [31:0] kval;
        logic [3:0]         crv;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef enum logic [1:0] {
        CRV_LIN    = 2'd0,
        CRV_EASE   = 2'd1,
        CRV_SMOOTH = 2'd2,
        CRV_RAT    = 2'd3
    } t_curve;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_REPL  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_READ,
        OP_CAPT,
        OP_INC,
        OP_REPL,
        OP_FULL,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_INS,
        OP_EMPTY,
        OP_EDGE,
        OP_DIV_T,
        OP_DIV_STEP,
        OP_T_SET,
        OP_SQ,
        OP_SMUL,
        OP_CFIN,
        OP_BMUL,
        OP_BADD
    } t_op;

    typedef struct packed {
        logic is_eval;
        logic idx_end;
        logic idx_zero;
        logic cur_lt;
        logic cur_eq;
        logic full;
        logic empty;
        logic j_at_idx;
        logic div_busy;
        logic code_rat;
        logic second;
    } t_dp_stat;

endpackage

FILE: rtl/core/kci_ram.sv
// generic single write port ram with registered read
module kci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/kci_dp.sv
// datapath: key table, search and shift registers, divider, curve and blend arithmetic
module kci_dp
    import kci_pkg::*;
#(
    parameter int MAX_KEYS = KCI_MAX_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op                i_op,
    input  logic               i_cmd,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_value,
    input  logic [1:0]         i_ease_in,
    input  logic [1:0]         i_ease_out,
    output t_dp_stat           o_stat,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_sample_value,
    output logic [31:0]        o_channel_length
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic               r_cmd;
    logic [31:0]        r_q;
    logic signed [31:0] r_val;
    logic [3:0]         r_crv;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_len;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_j;
    t_key               r_cur;
    t_key               r_prev;
    logic [47:0]        r_dn;
    logic [31:0]        r_dd;
    logic [31:0]        r_rem;
    logic [17:0]        r_quo;
    logic [5:0]         r_dcnt;
    logic [16:0]        r_t;
    t_curve             r_code;
    logic               r_second;
    logic [33:0]        r_mm;
    logic [34:0]        r_sp;
    logic [16:0]        r_a;
    logic [16:0]        r_b;
    logic signed [50:0] r_bp;
    t_status            r_status;
    logic signed [31:0] r_sample;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_key               w_wdata;
    logic [AW-1:0]      w_raddr;
    t_key               w_rdata;
    logic [KEY_W-1:0]   w_rdata_raw;
    t_key               w_new;

    logic [32:0]        w_rem_sh;
    logic               w_qbit;
    logic [16:0]        w_m;
    logic [17:0]        w_f;
    logic [19:0]        w_d;
    logic [18:0]        w_e;
    logic [16:0]        w_res;
    logic [16:0]        w_mt;
    logic signed [32:0] w_diff;
    logic signed [50:0] w_bsum;
    logic [CW-1:0]      w_jm1;

    assign w_new   = '{ktime: r_q, kval: r_val, crv: r_crv};
    assign w_rdata = t_key'(w_rdata_raw);
    assign w_jm1   = r_j - CW'(1);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_new;
        w_raddr = r_idx[AW-1:0];
        case (i_op)
            OP_REPL, OP_INS: begin
                w_we = 1'b1;
            end
            OP_SH_RD: begin
                w_raddr = w_jm1[AW-1:0];
            end
            OP_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = w_rdata;
            end
            default: begin
            end
        endcase
    end

    kci_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_KEYS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata_raw)
    );

    // restoring divide, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_dn[47]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dd});

    // curve arithmetic
    assign w_m = ((r_code == CRV_EASE) && (r_t >= 17'(ONE_Q16 / 2)))
                 ? 17'(ONE_Q16 - int'(r_t)) : r_t;
    assign w_f = 18'(3 * ONE_Q16) - {r_t, 1'b0};
    assign w_d = 20'(r_mm[33:15]) + 20'(ONE_Q16) - 20'({r_t, 1'b0});
    assign w_e = r_mm[33:15];

    always_comb begin
        case (r_code)
            CRV_LIN:    w_res = r_t;
            CRV_EASE:   w_res = (r_t < 17'(ONE_Q16 / 2)) ? w_e[16:0]
                                : 17'(19'(ONE_Q16) - w_e);
            CRV_SMOOTH: w_res = r_sp[32:16];
            CRV_RAT:    w_res = (r_quo > 18'(ONE_Q16)) ? 17'(ONE_Q16) : r_quo[16:0];
            default:    w_res = r_t;
        endcase
    end

    assign w_mt   = 17'((18'(r_a) + 18'(r_b)) >> 1);
    assign w_diff = {r_cur.kval[31], r_cur.kval} - {r_prev.kval[31], r_prev.kval};
    assign w_bsum = $signed({{19{r_prev.kval[31]}}, r_prev.kval}) + (r_bp >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
        end else begin
            case (i_op)
                OP_REPL: begin
                    if (r_q > r_len) begin
                        r_len <= r_q;
                    end
                end
                OP_INS: begin
                    r_count <= r_count + CW'(1);
                    if (r_q > r_len) begin
                        r_len <= r_q;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_cmd <= i_cmd;
                r_q   <= i_key_time;
                r_val <= i_key_value;
                r_crv <= {i_ease_out, i_ease_in};
                r_idx <= '0;
            end
            OP_CAPT: begin
                r_prev <= r_cur;
                r_cur  <= w_rdata;
            end
            OP_INC: begin
                r_idx <= r_idx + CW'(1);
            end
            OP_REPL: begin
                r_status <= ST_REPL;
                r_sample <= '0;
            end
            OP_FULL: begin
                r_status <= ST_FULL;
                r_sample <= '0;
            end
            OP_SH_INIT: begin
                r_j <= r_count;
            end
            OP_SH_WR: begin
                r_j <= w_jm1;
            end
            OP_INS: begin
                r_status <= ST_OK;
                r_sample <= '0;
            end
            OP_EMPTY: begin
                r_status <= ST_EMPTY;
                r_sample <= '0;
            end
            OP_EDGE: begin
                r_status <= ST_OK;
                r_sample <= r_cur.kval;
            end
            OP_DIV_T: begin
                r_dn   <= {r_q - r_prev.ktime, 16'd0};
                r_dd   <= r_cur.ktime - r_prev.ktime;
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= 6'(DIV_STEPS);
            end
            OP_DIV_STEP: begin
                r_rem  <= w_qbit ? 32'(w_rem_sh - {1'b0, r_dd}) : w_rem_sh[31:0];
                r_quo  <= {r_quo[16:0], w_qbit};
                r_dn   <= {r_dn[46:0], 1'b0};
                r_dcnt <= r_dcnt - 6'd1;
            end
            OP_T_SET: begin
                r_t      <= (r_quo > 18'(ONE_Q16)) ? 17'(ONE_Q16) : r_quo[16:0];
                r_code   <= t_curve'(r_prev.crv[3:2]);
                r_second <= 1'b0;
            end
            OP_SQ: begin
                r_mm <= 34'(w_m) * 34'(w_m);
            end
            OP_SMUL: begin
                r_sp   <= 35'(r_mm[32:16]) * 35'(w_f);
                r_dn   <= {14'd0, r_mm};
                r_dd   <= 32'(w_d);
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= 6'(DIV_STEPS);
            end
            OP_CFIN: begin
                if (!r_second) begin
                    r_a      <= w_res;
                    r_second <= 1'b1;
                    r_code   <= t_curve'(r_cur.crv[1:0]);
                end else begin
                    r_b <= w_res;
                end
            end
            OP_BMUL: begin
                r_bp <= 51'(w_diff) * 51'($signed({1'b0, w_mt}));
            end
            OP_BADD: begin
                r_status <= ST_OK;
                r_sample <= w_bsum[31:0];
            end
            default: begin
            end
        endcase
    end

    assign o_stat = '{
        is_eval:  (r_cmd == CMD_EVAL),
        idx_end:  (r_idx == r_count),
        idx_zero: (r_idx == '0),
        cur_lt:   (r_cur.ktime < r_q),
        cur_eq:   (r_cur.ktime == r_q),
        full:     (r_count >= CW'(MAX_KEYS)),
        empty:    (r_count == '0),
        j_at_idx: (r_j == r_idx),
        div_busy: (r_dcnt != '0),
        code_rat: (r_code == CRV_RAT),
        second:   r_second
    };

    assign o_status         = r_status;
    assign o_sample_value   = r_sample;
    assign o_channel_length = r_len;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS))
        else $error("key count beyond table size");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_INS) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

    a_len_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_len >= $past(r_len)))
        else $error("channel length decreased");

endmodule

FILE: rtl/core/kci_ctrl.sv
// controller: sequences search, insert shift, divides, curves and blend
module kci_ctrl
    import kci_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_op      o_op,
    output logic     busy,
    output logic     o_valid
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_CHK,
        S_SCAN_WAIT,
        S_SCAN_CMP,
        S_DECIDE,
        S_SH_CHK,
        S_SH_WR,
        S_DIVT,
        S_TSET,
        S_SQ,
        S_SMUL,
        S_DIVR,
        S_CFIN,
        S_BMUL,
        S_BADD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    t_op    w_op;

    always_comb begin
        n_state = r_state;
        w_op    = OP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_op    = OP_LOAD;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.idx_end) begin
                    n_state = S_DECIDE;
                end else begin
                    w_op    = OP_READ;
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                w_op    = OP_CAPT;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.cur_lt) begin
                    w_op    = OP_INC;
                    n_state = S_SCAN_CHK;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_eval) begin
                    if (!i_stat.idx_end && i_stat.cur_eq) begin
                        w_op    = OP_REPL;
                        n_state = S_DONE;
                    end else if (i_stat.full) begin
                        w_op    = OP_FULL;
                        n_state = S_DONE;
                    end else begin
                        w_op    = OP_SH_INIT;
                        n_state = S_SH_CHK;
                    end
                end else if (i_stat.empty) begin
                    w_op    = OP_EMPTY;
                    n_state = S_DONE;
                end else if (i_stat.idx_zero || i_stat.idx_end) begin
                    w_op    = OP_EDGE;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_DIV_T;
                    n_state = S_DIVT;
                end
            end
            S_SH_CHK: begin
                if (i_stat.j_at_idx) begin
                    w_op    = OP_INS;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_SH_RD;
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                w_op    = OP_SH_WR;
                n_state = S_SH_CHK;
            end
            S_DIVT: begin
                if (i_stat.div_busy) begin
                    w_op = OP_DIV_STEP;
                end else begin
                    n_state = S_TSET;
                end
            end
            S_TSET: begin
                w_op    = OP_T_SET;
                n_state = S_SQ;
            end
            S_SQ: begin
                w_op    = OP_SQ;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                w_op    = OP_SMUL;
                n_state = i_stat.code_rat ? S_DIVR : S_CFIN;
            end
            S_DIVR: begin
                if (i_stat.div_busy) begin
                    w_op = OP_DIV_STEP;
                end else begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                w_op    = OP_CFIN;
                n_state = i_stat.second ? S_BMUL : S_SQ;
            end
            S_BMUL: begin
                w_op    = OP_BMUL;
                n_state = S_BADD;
            end
            S_BADD: begin
                w_op    = OP_BADD;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_valid = (n_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_op    = w_op;
    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transaction did not raise busy");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a transaction");

endmodule

FILE: rtl/core/keyframe_curve_interpolator.sv
// top level of the keyframe curve interpolator (scalar channel)
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+---------------------------
//  command  | i_cmd i_key_time i_key_value i_ease_in i_ease_out | start high, busy low
//  result   | o_status o_sample_value o_channel_length        | o_valid one cycle, no stall
//
// add: scans keys to the slot, then shifts later keys up and inserts the key
// evaluate: scans keys, then a divide for t, another divide for each rational
// curve (up to two), and the curve and blend math;
// the search runs over the table ram and the divider is bit-serial
// reset clears key count and length; table ram contents are not cleared
// busy stays high from accept through the result strobe
module keyframe_curve_interpolator
    import kci_pkg::*;
#(
    parameter int MAX_KEYS = KCI_MAX_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_value,
    input  logic [1:0]         i_ease_in,
    input  logic [1:0]         i_ease_out,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_sample_value,
    output logic [31:0]        o_channel_length
);

    t_op      w_op;
    t_dp_stat w_stat;

    kci_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (w_stat),
        .o_op   (w_op),
        .busy   (busy),
        .o_valid(o_valid)
    );

    kci_dp #(
        .MAX_KEYS(MAX_KEYS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .i_cmd           (i_cmd),
        .i_key_time      (i_key_time),
        .i_key_value     (i_key_value),
        .i_ease_in       (i_ease_in),
        .i_ease_out      (i_ease_out),
        .o_stat          (w_stat),
        .o_status        (o_status),
        .o_sample_value  (o_sample_value),
        .o_channel_length(o_channel_length)
    );

endmodule
